[rtl/rswu_pkg.sv]
// Shared types and constants for the JPEG restart window splicer.
// Used by the control datapath, the position table and the top level.
package rswu_pkg;

  localparam int DefMaxIntervals = 1024;
  localparam int DefPositionBits = 40;

  localparam int IdxBits  = 12;   // window index, wraps at 4096
  localparam int SIdxBits = 13;   // window index plus window width
  localparam int CmpBits  = 18;   // wide enough to hold the table depth

  localparam logic [7:0] MarkerPrefix = 8'hFF;
  localparam logic [7:0] RstFirst     = 8'hD0;
  localparam logic [7:0] RstEnd       = 8'hD8;
  localparam logic [7:0] EoiCode      = 8'hD9;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_BEGIN = 2'd1,
    ACT_BYTE  = 2'd2,
    ACT_EOF   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_INTERVAL_COUNT = 2'd0,
    REG_TOP_LEFT_INDEX = 2'd1,
    REG_WINDOW_WIDTH   = 2'd2,
    REG_ROW_STRIDE     = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_WINDOW = 4'b0010,
    PH_SKIP   = 4'b0100,
    PH_HALTED = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [10:0] interval_count;
    logic [9:0]  top_left_index;
    logic [10:0] window_width;
    logic [10:0] row_stride;
  } cfg_t;

  typedef struct packed {
    status_t    status;
    logic       last;
    logic [7:0] data;
  } out_word_t;

endpackage

[rtl/rswu_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies; the read returns the old contents on a same-address write.
module rswu_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rswu_table.sv]
// Restart position table: two RAM copies read at the next window's start and stop
// index every cycle, with write forwarding, plus a shadow of entry 0.
// Depends on rswu_pkg and rswu_ram.
module rswu_table #(
  parameter int MAX_INTERVALS = rswu_pkg::DefMaxIntervals,
  parameter int POSITION_BITS = rswu_pkg::DefPositionBits
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(MAX_INTERVALS)-1:0] waddr,
  input  logic [POSITION_BITS-1:0]         wdata,
  input  logic [rswu_pkg::IdxBits-1:0]     start_idx,
  input  logic [rswu_pkg::SIdxBits-1:0]    stop_idx,
  output logic [POSITION_BITS-1:0]         start_data,
  output logic [POSITION_BITS-1:0]         stop_data,
  output logic [POSITION_BITS-1:0]         entry0
);

  localparam int AW = $clog2(MAX_INTERVALS);

  logic [AW+rswu_pkg::IdxBits-1:0]  start_ext;
  logic [AW+rswu_pkg::SIdxBits-1:0] stop_ext;
  logic [AW-1:0]                    start_addr;
  logic [AW-1:0]                    stop_addr;
  logic [POSITION_BITS-1:0]         start_ram;
  logic [POSITION_BITS-1:0]         stop_ram;
  logic                             start_hit;
  logic                             stop_hit;
  logic [POSITION_BITS-1:0]         fwd_data;

  // Indices beyond the table are never used, so plain truncation is enough.
  assign start_ext  = {{AW{1'b0}}, start_idx};
  assign stop_ext   = {{AW{1'b0}}, stop_idx};
  assign start_addr = start_ext[AW-1:0];
  assign stop_addr  = stop_ext[AW-1:0];

  rswu_ram #(.WIDTH(POSITION_BITS), .DEPTH(MAX_INTERVALS)) u_start_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (start_addr),
    .rdata (start_ram)
  );

  rswu_ram #(.WIDTH(POSITION_BITS), .DEPTH(MAX_INTERVALS)) u_stop_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (stop_addr),
    .rdata (stop_ram)
  );

  always_ff @(posedge clk) begin
    start_hit <= we && (waddr == start_addr);
    stop_hit  <= we && (waddr == stop_addr);
    fwd_data  <= wdata;
    if (we && (waddr == '0)) begin
      entry0 <= wdata;
    end
  end

  assign start_data = start_hit ? fwd_data : start_ram;
  assign stop_data  = stop_hit  ? fwd_data : stop_ram;

endmodule

[rtl/rswu_ctrl.sv]
// Splicer control: per-byte window tracking, marker renumbering, table write
// and prefetch addressing, and the four-word output queue. Depends on rswu_pkg.
module rswu_ctrl #(
  parameter int MAX_INTERVALS = rswu_pkg::DefMaxIntervals,
  parameter int POSITION_BITS = rswu_pkg::DefPositionBits
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rswu_pkg::cfg_t                   cfg,
  input  logic                             cfg_wr,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rswu_pkg::action_t                in_action,
  input  logic [9:0]                       in_entry_index,
  input  logic [39:0]                      in_entry_position,
  input  logic [7:0]                       in_data_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rswu_pkg::out_word_t              out_word,
  output logic                             tbl_we,
  output logic [$clog2(MAX_INTERVALS)-1:0] tbl_waddr,
  output logic [POSITION_BITS-1:0]         tbl_wdata,
  output logic [rswu_pkg::IdxBits-1:0]     rd_start_idx,
  output logic [rswu_pkg::SIdxBits-1:0]    rd_stop_idx,
  input  logic [POSITION_BITS-1:0]         start_data,
  input  logic [POSITION_BITS-1:0]         stop_data,
  input  logic [POSITION_BITS-1:0]         entry0
);

  localparam int AW = $clog2(MAX_INTERVALS);
  localparam int PB = POSITION_BITS;
  localparam logic [rswu_pkg::CmpBits-1:0] MaxL = rswu_pkg::CmpBits'(MAX_INTERVALS);

  // State registers
  logic [PB-1:0]                    byte_count, byte_count_next;
  logic [rswu_pkg::IdxBits-1:0]     window_index, window_index_next;
  logic [PB-1:0]                    window_start, window_start_next;
  logic [PB-1:0]                    window_stop, window_stop_next;
  logic                             stop_unbounded, stop_unbounded_next;
  rswu_pkg::phase_t                 phase, phase_next;
  logic [2:0]                       marker_number, marker_number_next;
  logic                             prev_was_ff, prev_was_ff_next;
  logic                             seen_any_byte, seen_any_byte_next;
  logic                             pf_ok;

  // Output queue
  rswu_pkg::out_word_t              q_mem [4];
  logic [1:0]                       q_rp, q_wp;
  logic [2:0]                       q_cnt;
  logic [1:0]                       n_push;
  rswu_pkg::out_word_t              w0, w1;
  logic                             pop;

  // Byte datapath
  logic                             acc;
  logic [rswu_pkg::IdxBits-1:0]     nidx;
  logic [rswu_pkg::SIdxBits-1:0]    sidx;
  logic                             nidx_ok, sidx_ok;
  logic                             hdr_pass, jump;
  rswu_pkg::phase_t                 ph;
  logic                             pff;
  logic                             is_rst;
  logic [PB+39:0]                   pos_ext;
  logic [AW+9:0]                    eidx_ext;

  assign acc = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  assign nidx = window_index + {1'b0, cfg.row_stride};
  assign sidx = {1'b0, nidx} + {2'b0, cfg.window_width};
  assign nidx_ok = (nidx < {1'b0, cfg.interval_count}) &&
                   ({6'b0, nidx} < MaxL);
  assign sidx_ok = (sidx < {2'b0, cfg.interval_count}) &&
                   ({5'b0, sidx} < MaxL);

  assign is_rst = (in_data_byte >= rswu_pkg::RstFirst) && (in_data_byte < rswu_pkg::RstEnd);

  assign pos_ext   = {{PB{1'b0}}, in_entry_position};
  assign eidx_ext  = {{AW{1'b0}}, in_entry_index};
  assign tbl_we    = acc && (in_action == rswu_pkg::ACT_LOAD) &&
                     ({8'b0, in_entry_index} < MaxL);
  assign tbl_waddr = eidx_ext[AW-1:0];
  assign tbl_wdata = pos_ext[PB-1:0];

  // The table is read for the window that follows the next state, so the data
  // lines up with the register contents in the next cycle.
  assign rd_start_idx = window_index_next + {1'b0, cfg.row_stride};
  assign rd_stop_idx  = {1'b0, rd_start_idx} + {2'b0, cfg.window_width};

  always_comb begin
    byte_count_next     = byte_count;
    window_index_next   = window_index;
    window_start_next   = window_start;
    window_stop_next    = window_stop;
    stop_unbounded_next = stop_unbounded;
    phase_next          = phase;
    marker_number_next  = marker_number;
    prev_was_ff_next    = prev_was_ff;
    seen_any_byte_next  = seen_any_byte;
    n_push              = 2'd0;
    w0                  = '{status: rswu_pkg::ST_OK, last: 1'b1, data: in_data_byte};
    w1                  = '{status: rswu_pkg::ST_OK, last: 1'b1, data: rswu_pkg::EoiCode};
    hdr_pass            = 1'b0;
    jump                = 1'b0;
    ph                  = phase;
    pff                 = prev_was_ff;
    if (acc) begin
      case (in_action)
        rswu_pkg::ACT_BEGIN: begin
          byte_count_next    = '0;
          marker_number_next = '0;
          prev_was_ff_next   = 1'b0;
          seen_any_byte_next = 1'b0;
          window_index_next  = {2'b0, cfg.top_left_index} - {1'b0, cfg.row_stride};
          window_start_next  = '0;
          if (cfg.interval_count == '0) begin
            phase_next          = rswu_pkg::PH_WINDOW;
            stop_unbounded_next = 1'b1;
            window_stop_next    = '0;
          end else begin
            phase_next          = rswu_pkg::PH_HEADER;
            stop_unbounded_next = 1'b0;
            window_stop_next    = entry0;
          end
        end
        rswu_pkg::ACT_EOF: begin
          if (!seen_any_byte) begin
            n_push = 2'd1;
            w0     = '{status: rswu_pkg::ST_EMPTY, last: 1'b1, data: 8'h00};
          end else begin
            n_push = 2'd2;
            w0     = '{status: rswu_pkg::ST_OK, last: 1'b0, data: rswu_pkg::MarkerPrefix};
          end
        end
        rswu_pkg::ACT_BYTE: begin
          byte_count_next    = byte_count + PB'(1);
          seen_any_byte_next = 1'b1;
          if (phase != rswu_pkg::PH_HALTED) begin
            if (cfg.interval_count == '0) begin
              n_push = 2'd1;
            end else begin
              if (phase == rswu_pkg::PH_HEADER && byte_count < window_stop) begin
                hdr_pass = 1'b1;
                n_push   = 2'd1;
              end else if (phase == rswu_pkg::PH_HEADER ||
                           (phase == rswu_pkg::PH_WINDOW && !stop_unbounded &&
                            byte_count >= window_stop)) begin
                jump = 1'b1;
              end else if (phase == rswu_pkg::PH_SKIP && byte_count >= window_start) begin
                ph = rswu_pkg::PH_WINDOW;
              end
              if (jump) begin
                if (!nidx_ok) begin
                  ph     = rswu_pkg::PH_HALTED;
                  n_push = 2'd1;
                  w0     = '{status: rswu_pkg::ST_RANGE, last: 1'b1, data: 8'h00};
                end else begin
                  window_index_next = nidx;
                  window_start_next = start_data;
                  if (sidx_ok) begin
                    window_stop_next    = stop_data;
                    stop_unbounded_next = 1'b0;
                  end else begin
                    stop_unbounded_next = 1'b1;
                  end
                  pff = 1'b0;
                  ph  = (start_data > byte_count) ? rswu_pkg::PH_SKIP : rswu_pkg::PH_WINDOW;
                end
              end
              phase_next       = ph;
              prev_was_ff_next = pff;
              if (!hdr_pass && ph == rswu_pkg::PH_WINDOW) begin
                n_push = 2'd1;
                if (pff && is_rst) begin
                  w0.data            = {5'b11010, marker_number};
                  marker_number_next = marker_number + 3'd1;
                end
                prev_was_ff_next = (in_data_byte == rswu_pkg::MarkerPrefix);
              end
            end
          end
        end
        default: begin
          // Table loads touch only the position table.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      window_index   <= '0;
      window_start   <= '0;
      window_stop    <= '0;
      stop_unbounded <= 1'b0;
      phase          <= rswu_pkg::PH_HEADER;
      marker_number  <= '0;
      prev_was_ff    <= 1'b0;
      seen_any_byte  <= 1'b0;
      pf_ok          <= 1'b0;
      q_rp           <= '0;
      q_wp           <= '0;
      q_cnt          <= '0;
    end else begin
      byte_count     <= byte_count_next;
      window_index   <= window_index_next;
      window_start   <= window_start_next;
      window_stop    <= window_stop_next;
      stop_unbounded <= stop_unbounded_next;
      phase          <= phase_next;
      marker_number  <= marker_number_next;
      prev_was_ff    <= prev_was_ff_next;
      seen_any_byte  <= seen_any_byte_next;
      // A register write changes the prefetch addresses; hold input until the
      // table has been read again.
      pf_ok          <= !cfg_wr;
      q_rp           <= q_rp + {1'b0, pop};
      q_wp           <= q_wp + n_push;
      q_cnt          <= q_cnt + {1'b0, n_push} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_mem[q_wp] <= w0;
    end
    if (n_push == 2'd2) begin
      q_mem[q_wp + 2'd1] <= w1;
    end
  end

  // Input is taken only while two entries are free, so one item can never overflow the queue.
  assign in_ready  = pf_ok && (q_cnt <= 3'd2);
  assign out_valid = (q_cnt != 3'd0);
  assign out_word  = q_mem[q_rp];

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (rst) q_cnt <= 3'd4)
    else $error("output queue overflow");

  a_cfg_interlock: assert property (@(posedge clk) disable iff (rst) cfg_wr |=> !in_ready)
    else $error("input taken before table prefetch refreshed");

  a_range_halts: assert property (@(posedge clk) disable iff (rst)
    (acc && in_action == rswu_pkg::ACT_BYTE && n_push == 2'd1 &&
     w0.status == rswu_pkg::ST_RANGE) |=> phase == rswu_pkg::PH_HALTED)
    else $error("range error without halt");

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    (acc && in_action == rswu_pkg::ACT_BYTE && phase == rswu_pkg::PH_HALTED)
    |-> n_push == 2'd0)
    else $error("word produced while halted");
`endif

endmodule

[rtl/jpeg_restart_window_splicer_unit.sv]
// Channel   | Direction | Payload
// s_axis    | in        | tuser: action; tdata: entry_index, entry_position, data_byte
// m_axis    | out       | tuser: status; tdata: out_byte; tlast: last
// APB       | in/out    | four configuration registers at byte addresses 0, 4, 8, 12
//
// One item per cycle while the output queue has room, including items that jump to
// the next row's window: the start and stop positions of the next window are read
// every cycle from two RAM copies. An end-of-file item yields two words, or one
// empty-status word if no byte came; the four-word output queue absorbs them. After
// each register write, input waits while prefetch reads repeat with new settings.
// Reset is synchronous; the table is undefined until loaded and needs no clearing.
//
// Top level of the restart window splicer: APB registers and the instances of
// rswu_ctrl and rswu_table. Depends on rswu_pkg.
module jpeg_restart_window_splicer_unit #(
  parameter int MAX_INTERVALS = rswu_pkg::DefMaxIntervals,
  parameter int POSITION_BITS = rswu_pkg::DefPositionBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // entry_index[9:0], entry_position[49:10], data_byte[57:50]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_INTERVALS);

  rswu_pkg::cfg_t                cfg;
  logic                          cfg_wr;
  rswu_pkg::reg_index_t          reg_sel;
  rswu_pkg::out_word_t           out_word;
  logic                          tbl_we;
  logic [AW-1:0]                 tbl_waddr;
  logic [POSITION_BITS-1:0]      tbl_wdata;
  logic [rswu_pkg::IdxBits-1:0]  rd_start_idx;
  logic [rswu_pkg::SIdxBits-1:0] rd_stop_idx;
  logic [POSITION_BITS-1:0]      start_data;
  logic [POSITION_BITS-1:0]      stop_data;
  logic [POSITION_BITS-1:0]      entry0;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = rswu_pkg::reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval_count <= 11'd0;
      cfg.top_left_index <= 10'd0;
      cfg.window_width   <= 11'd1;
      cfg.row_stride     <= 11'd1;
    end else if (cfg_wr) begin
      case (reg_sel)
        rswu_pkg::REG_INTERVAL_COUNT: cfg.interval_count <= pwdata[10:0];
        rswu_pkg::REG_TOP_LEFT_INDEX: cfg.top_left_index <= pwdata[9:0];
        rswu_pkg::REG_WINDOW_WIDTH:   cfg.window_width   <= pwdata[10:0];
        rswu_pkg::REG_ROW_STRIDE:     cfg.row_stride     <= pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      rswu_pkg::REG_INTERVAL_COUNT: prdata = {21'b0, cfg.interval_count};
      rswu_pkg::REG_TOP_LEFT_INDEX: prdata = {22'b0, cfg.top_left_index};
      rswu_pkg::REG_WINDOW_WIDTH:   prdata = {21'b0, cfg.window_width};
      rswu_pkg::REG_ROW_STRIDE:     prdata = {21'b0, cfg.row_stride};
      default:                      prdata = 32'b0;
    endcase
  end

  rswu_ctrl #(.MAX_INTERVALS(MAX_INTERVALS), .POSITION_BITS(POSITION_BITS)) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .cfg_wr            (cfg_wr),
    .in_valid          (s_axis_tvalid),
    .in_ready          (s_axis_tready),
    .in_action         (rswu_pkg::action_t'(s_axis_tuser)),
    .in_entry_index    (s_axis_tdata[9:0]),
    .in_entry_position (s_axis_tdata[49:10]),
    .in_data_byte      (s_axis_tdata[57:50]),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .out_word          (out_word),
    .tbl_we            (tbl_we),
    .tbl_waddr         (tbl_waddr),
    .tbl_wdata         (tbl_wdata),
    .rd_start_idx      (rd_start_idx),
    .rd_stop_idx       (rd_stop_idx),
    .start_data        (start_data),
    .stop_data         (stop_data),
    .entry0            (entry0)
  );

  rswu_table #(.MAX_INTERVALS(MAX_INTERVALS), .POSITION_BITS(POSITION_BITS)) u_table (
    .clk        (clk),
    .we         (tbl_we),
    .waddr      (tbl_waddr),
    .wdata      (tbl_wdata),
    .start_idx  (rd_start_idx),
    .stop_idx   (rd_stop_idx),
    .start_data (start_data),
    .stop_data  (stop_data),
    .entry0     (entry0)
  );

  assign m_axis_tdata = out_word.data;
  assign m_axis_tuser = out_word.status;
  assign m_axis_tlast = out_word.last;

endmodule
